// ===== rtl/core/tsq_pkg.sv =====
// Package: shared constants and control/status types for the touch sample qualifier.
`default_nettype none
package tsq_pkg;
    localparam int ADC_BITS = 12;
    localparam int CFG_W    = 16;
    localparam int PROD_W   = 32;
    localparam int P_W      = PROD_W - ADC_BITS;
    localparam int CNT_W    = $clog2(PROD_W);
    localparam int IDX_W    = 2;
    localparam int ROUND_ADD = (1 << (ADC_BITS - 1)) - 1;
    localparam int ADC_MAX   = (1 << ADC_BITS) - 1;

    typedef enum logic [IDX_W-1:0] {
        CFG_PLATE_OHMS   = 2'd0,
        CFG_MAX_PRESSURE = 2'd1,
        CFG_SENSE        = 2'd2
    } t_cfg_idx;

    localparam logic EV_TOUCH   = 1'b0;
    localparam logic EV_RELEASE = 1'b1;

    typedef struct packed {
        logic load;
        logic mul1;
        logic mul2;
        logic div_step;
        logic round;
        logic out_load;
        logic out_kind;
    } t_dp_cmd;

    typedef struct packed {
        logic down_before;
        logic down_after;
        logic sense;
        logic p_zero;
        logic p_le_max;
    } t_dp_stat;
endpackage
`default_nettype wire

// ===== rtl/core/tsq_in_if.sv =====
// Interface: input channel carrying one measurement round per item.
`default_nettype none
interface tsq_in_if;
    import tsq_pkg::*;
    logic                valid;
    logic                ready;
    logic [ADC_BITS-1:0] raw_x;
    logic [ADC_BITS-1:0] raw_y;
    logic [ADC_BITS-1:0] raw_z1;
    logic [ADC_BITS-1:0] raw_z2;
    logic                pen_before;
    logic                pen_after;

    modport source (output valid, raw_x, raw_y, raw_z1, raw_z2, pen_before, pen_after,
                    input ready);
    modport sink (input valid, raw_x, raw_y, raw_z1, raw_z2, pen_before, pen_after,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/core/tsq_out_if.sv =====
// Interface: output channel carrying one touch or release event per item.
`default_nettype none
interface tsq_out_if;
    import tsq_pkg::*;
    logic                valid;
    logic                ready;
    logic                event_kind;
    logic [ADC_BITS-1:0] pos_x;
    logic [ADC_BITS-1:0] pos_y;
    logic [CFG_W-1:0]    pressure;

    modport source (output valid, event_kind, pos_x, pos_y, pressure, input ready);
    modport sink (input valid, event_kind, pos_x, pos_y, pressure, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/tsq_datapath.sv =====
// Datapath: config registers, pressure multiplies, serial divider and event register.
`default_nettype none
module tsq_datapath (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [tsq_pkg::IDX_W-1:0]    i_cfg_idx,
    input  wire logic [tsq_pkg::CFG_W-1:0]    i_cfg_data,
    input  wire logic [tsq_pkg::ADC_BITS-1:0] i_raw_x,
    input  wire logic [tsq_pkg::ADC_BITS-1:0] i_raw_y,
    input  wire logic [tsq_pkg::ADC_BITS-1:0] i_raw_z1,
    input  wire logic [tsq_pkg::ADC_BITS-1:0] i_raw_z2,
    input  wire logic                         i_pen_before,
    input  wire logic                         i_pen_after,
    input  wire tsq_pkg::t_dp_cmd             i_cmd,
    output tsq_pkg::t_dp_stat                 o_stat,
    output logic                              o_event_kind,
    output logic [tsq_pkg::ADC_BITS-1:0]      o_pos_x,
    output logic [tsq_pkg::ADC_BITS-1:0]      o_pos_y,
    output logic [tsq_pkg::CFG_W-1:0]         o_pressure
);
    import tsq_pkg::*;

    logic [CFG_W-1:0]    r_plate_ohms;
    logic [CFG_W-1:0]    r_max_pressure;
    logic                r_sense;

    logic [ADC_BITS-1:0] r_x;
    logic [ADC_BITS-1:0] r_y;
    logic [ADC_BITS-1:0] r_z1;
    logic                r_down_after;
    logic                r_force_zero;
    logic [PROD_W-1:0]   r_prod;
    logic [PROD_W-1:0]   r_quo;
    logic [ADC_BITS-1:0] r_rem;
    logic [P_W-1:0]      r_p;

    logic [ADC_BITS-1:0]        n_x;
    logic [PROD_W-1:0]          n_diff;
    logic [PROD_W+ADC_BITS-1:0] n_mul1;
    logic [PROD_W+CFG_W-1:0]    n_mul2;
    logic [ADC_BITS:0]          n_trial;
    logic                       n_qbit;
    logic [PROD_W-1:0]          n_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plate_ohms   <= CFG_W'(1);
            r_max_pressure <= CFG_W'(ADC_MAX);
            r_sense        <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PLATE_OHMS:   r_plate_ohms   <= i_cfg_data;
                CFG_MAX_PRESSURE: r_max_pressure <= i_cfg_data;
                CFG_SENSE:        r_sense        <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_x     = (i_raw_x == ADC_BITS'(ADC_MAX)) ? '0 : i_raw_x;
        n_diff  = PROD_W'(i_raw_z2) - PROD_W'(i_raw_z1);
        n_mul1  = r_prod * r_x;
        n_mul2  = r_prod * r_plate_ohms;
        n_trial = {r_rem, r_quo[PROD_W-1]};
        n_qbit  = n_trial >= {1'b0, r_z1};
        n_sum   = r_quo + PROD_W'(ROUND_ADD);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x          <= n_x;
            r_y          <= i_raw_y;
            r_z1         <= i_raw_z1;
            r_down_after <= r_sense ? i_pen_after : 1'b1;
            r_force_zero <= (n_x == '0) || (i_raw_z1 == '0);
            r_prod       <= n_diff;
        end
        if (i_cmd.mul1) begin
            r_prod <= n_mul1[PROD_W-1:0];
        end
        if (i_cmd.mul2) begin
            r_quo <= n_mul2[PROD_W-1:0];
            r_rem <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= n_qbit ? ADC_BITS'(n_trial - {1'b0, r_z1}) : n_trial[ADC_BITS-1:0];
            r_quo <= {r_quo[PROD_W-2:0], n_qbit};
        end
        if (i_cmd.round) begin
            r_p <= r_force_zero ? '0 : n_sum[PROD_W-1:ADC_BITS];
        end
        if (i_cmd.out_load) begin
            o_event_kind <= i_cmd.out_kind;
            o_pos_x      <= (i_cmd.out_kind == EV_RELEASE) ? '0 : r_x;
            o_pos_y      <= (i_cmd.out_kind == EV_RELEASE) ? '0 : r_y;
            o_pressure   <= (i_cmd.out_kind == EV_RELEASE) ? '0 : r_p[CFG_W-1:0];
        end
    end

    always_comb begin
        o_stat.down_before = r_sense ? i_pen_before : 1'b1;
        o_stat.down_after  = r_down_after;
        o_stat.sense       = r_sense;
        o_stat.p_zero      = (r_p == '0);
        o_stat.p_le_max    = PROD_W'(r_p) <= PROD_W'(r_max_pressure);
    end
endmodule
`default_nettype wire

// ===== rtl/core/tsq_ctrl.sv =====
// Controller: sequences one round through the datapath and owns the session flag.
`default_nettype none
module tsq_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic              i_out_ready,
    output logic                   o_out_valid,
    input  wire tsq_pkg::t_dp_stat i_stat,
    output tsq_pkg::t_dp_cmd       o_cmd
);
    import tsq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_DIV,
        S_ROUND,
        S_DONE
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_cnt;
    logic             r_session;
    logic             r_skip;
    logic             r_skip_emit;
    logic             r_out_valid;

    logic n_accept;
    logic n_go;
    logic n_rel;
    logic n_has;

    always_comb begin
        n_accept = (r_state == S_IDLE) && i_in_valid;
        n_go     = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
        n_rel    = r_skip || (i_stat.p_zero && !i_stat.sense) || !i_stat.down_after;
        n_has    = r_skip ? r_skip_emit : (n_rel || i_stat.p_le_max);

        o_cmd.load     = n_accept;
        o_cmd.mul1     = (r_state == S_MUL1);
        o_cmd.mul2     = (r_state == S_MUL2);
        o_cmd.div_step = (r_state == S_DIV);
        o_cmd.round    = (r_state == S_ROUND);
        o_cmd.out_load = n_go && n_has;
        o_cmd.out_kind = n_rel ? EV_RELEASE : EV_TOUCH;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_session   <= 1'b0;
            r_skip      <= 1'b0;
            r_skip_emit <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (n_accept) begin
                        if (!i_stat.down_before) begin
                            r_skip      <= 1'b1;
                            r_skip_emit <= r_session;
                            r_session   <= 1'b0;
                            r_state     <= S_DONE;
                        end else begin
                            r_skip    <= 1'b0;
                            r_session <= 1'b1;
                            r_state   <= S_MUL1;
                        end
                    end
                end
                S_MUL1: begin
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_cnt   <= CNT_W'(PROD_W - 1);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (n_go) begin
                        if (n_has) begin
                            r_out_valid <= 1'b1;
                            if (n_rel) begin
                                r_session <= 1'b0;
                            end
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_valid_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("event raised outside of done state");

    a_pen_up_skips: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_accept && !i_stat.down_before) |=> (r_state == S_DONE && !r_session))
        else $error("pen-up round did not close the session");

    a_release_ends_session: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.out_load && o_cmd.out_kind == EV_RELEASE) |=> !r_session)
        else $error("session still active after release");

    a_div_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL2) |=> (r_state == S_DIV && r_cnt == CNT_W'(PROD_W - 1)))
        else $error("divider not started with full count");
endmodule
`default_nettype wire

// ===== rtl/core/touch_sample_qualifier.sv =====
// Top level: touch sample qualifier built from controller and datapath.
// Each accepted round is worked in order: the multiplications in MUL1 and MUL2,
// the restoring divider that yields one quotient bit per cycle for all 32 quotient
// bits, a rounding step and a decision step that waits for the output register to
// be free; the next round is accepted only once the controller is back in idle.
// A pen-up round skips the arithmetic and goes straight to the decision step.
// The event sits in an output register while the next round is worked on.
`default_nettype none
module touch_sample_qualifier (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [tsq_pkg::IDX_W-1:0] i_cfg_idx,
    input  wire logic [tsq_pkg::CFG_W-1:0] i_cfg_data,
    tsq_in_if.sink                         i_in_chan,
    tsq_out_if.source                      o_out_chan
);
    import tsq_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    tsq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_chan.valid),
        .o_in_ready  (i_in_chan.ready),
        .i_out_ready (o_out_chan.ready),
        .o_out_valid (o_out_chan.valid),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    tsq_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_raw_x      (i_in_chan.raw_x),
        .i_raw_y      (i_in_chan.raw_y),
        .i_raw_z1     (i_in_chan.raw_z1),
        .i_raw_z2     (i_in_chan.raw_z2),
        .i_pen_before (i_in_chan.pen_before),
        .i_pen_after  (i_in_chan.pen_after),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .o_event_kind (o_out_chan.event_kind),
        .o_pos_x      (o_out_chan.pos_x),
        .o_pos_y      (o_out_chan.pos_y),
        .o_pressure   (o_out_chan.pressure)
    );
endmodule
`default_nettype wire
